[hdl/csvt_pkg.sv]
// Package of the CSV field tokenizer: character codes, parse modes and the
// state and result types shared by the step logic and the top level.
// Depends on nothing.
`default_nettype none

package csvt_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef logic [1:0] csvt_mode_type;

   localparam csvt_mode_type MODE_PLAIN  = 2'd0;
   localparam csvt_mode_type MODE_QUOTED = 2'd1;
   localparam csvt_mode_type MODE_QPEND  = 2'd2;
   localparam csvt_mode_type MODE_CRPEND = 2'd3;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_EOI  = 1'b1;

   typedef struct packed {
      csvt_mode_type parse_mode;
      logic          field_has_bytes;
      logic          row_has_fields;
   } csvt_state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] in_byte;
   } csvt_item_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       field_end;
      logic       field_was_empty;
      logic       row_end;
   } csvt_result_type;

endpackage

`default_nettype wire

[hdl/csvt_if.sv]
// Valid/ready channel interfaces of the CSV field tokenizer: the byte input
// channel and the token result channel. Depends on nothing.
`default_nettype none

interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface csvt_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] out_byte;
   logic       field_end;
   logic       field_was_empty;
   logic       row_end;

   modport source (output valid, output has_byte, output out_byte, output field_end,
                   output field_was_empty, output row_end, input ready);
   modport sink   (input valid, input has_byte, input out_byte, input field_end,
                   input field_was_empty, input row_end, output ready);
endinterface

`default_nettype wire

[hdl/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: input register, parse state, step
// logic and result register. Depends on csvt_pkg, csvt_if.sv and csvt_step.
//
// Usage: the block takes one item on the req channel each cycle unless rsp
// stalls. An item is either a data byte (func low, byte in in_byte) or an
// end-of-input mark (func high). Each item gives at most one item on the rsp
// channel: a field content byte with the quoting removed, a field end (with a
// flag telling whether the field was empty), a row end, or a combination of
// the marks. Items that give nothing (an opening quote, the first quote of a
// pair, the LF of a CR LF pair) simply vanish from the output stream.
// Throughput is one item per cycle while the receiver does not stall. The
// item is captured in the input register, then the parse state and the
// result register are updated together from it. The state update is the
// loop that sets that rate.
// Reset, synchronous and active high, empties both registers and returns
// the parser to an unquoted, empty field at the start of a row.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more item, and req.ready then drops until the
// result is taken.
`default_nettype none

module csv_field_tokenizer
   import csvt_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   csvt_req_if.sink     req,
   csvt_rsp_if.source   rsp
);

   logic            in_valid_ff;
   logic            in_valid_in;
   csvt_item_type   in_item_ff;
   csvt_item_type   in_item_in;

   csvt_state_type  state_ff;
   csvt_state_type  state_in;
   csvt_state_type  step_state;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   csvt_result_type rsp_item_ff;
   csvt_result_type rsp_item_in;

   logic            step_produce;
   csvt_result_type step_result;
   logic            advance;
   logic            take;

   // The pipeline moves whenever the result register is empty or is being
   // read out in this cycle.
   assign advance   = ~rsp_valid_ff | rsp.ready;
   assign req.ready = ~in_valid_ff | advance;
   assign take      = req.valid & req.ready;

   csvt_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (step_state),
      .produce    (step_produce),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b0;
         if (in_valid_ff) begin
            state_in     = step_state;
            rsp_valid_in = step_produce;
            rsp_item_in  = step_result;
         end
      end
      if (take) begin
         in_valid_in        = 1'b1;
         in_item_in.func    = req.func;
         in_item_in.in_byte = req.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.has_byte        = rsp_item_ff.has_byte;
   assign rsp.out_byte        = rsp_item_ff.out_byte;
   assign rsp.field_end       = rsp_item_ff.field_end;
   assign rsp.field_was_empty = rsp_item_ff.field_was_empty;
   assign rsp.row_end         = rsp_item_ff.row_end;

endmodule

`default_nettype wire

[hdl/csvt_step.sv]
// Next-state and result logic of the CSV tokenizer for one item.
// Purely combinational; depends on csvt_pkg.
`default_nettype none

module csvt_step
   import csvt_pkg::*;
(
   input  wire csvt_state_type  state,
   input  wire csvt_item_type   item,
   output csvt_state_type       state_next,
   output logic                 produce,
   output csvt_result_type      result
);

   csvt_state_type  plain_state;
   logic            plain_produce;
   csvt_result_type plain_result;
   logic            is_quote;

   assign is_quote = (item.in_byte == CH_QUOTE);

   // Handling of a byte as in an unquoted field.
   always_comb begin
      plain_state   = state;
      plain_produce = 1'b1;
      plain_result  = '0;
      plain_state.parse_mode = MODE_PLAIN;
      if (is_quote) begin
         plain_state.parse_mode = MODE_QUOTED;
         plain_produce = 1'b0;
      end else if (item.in_byte == CH_COMMA) begin
         plain_result.field_end       = 1'b1;
         plain_result.field_was_empty = ~state.field_has_bytes;
         plain_state.field_has_bytes  = 1'b0;
         plain_state.row_has_fields   = 1'b1;
      end else if ((item.in_byte == CH_LF) || (item.in_byte == CH_CR)) begin
         plain_result.field_end       = 1'b1;
         plain_result.field_was_empty = ~state.field_has_bytes;
         plain_result.row_end         = 1'b1;
         plain_state.field_has_bytes  = 1'b0;
         plain_state.row_has_fields   = 1'b0;
         if (item.in_byte == CH_CR) begin
            plain_state.parse_mode = MODE_CRPEND;
         end
      end else begin
         plain_result.has_byte       = 1'b1;
         plain_result.out_byte       = item.in_byte;
         plain_state.field_has_bytes = 1'b1;
      end
   end

   always_comb begin
      state_next = state;
      produce    = 1'b0;
      result     = '0;
      if (item.func == FUNC_EOI) begin
         // End of input closes what is open and returns to the reset state.
         state_next = '0;
         if (state.parse_mode == MODE_CRPEND) begin
            produce = 1'b0;
         end else if (state.field_has_bytes || (state.parse_mode == MODE_QUOTED)) begin
            produce                = 1'b1;
            result.field_end       = 1'b1;
            result.field_was_empty = ~state.field_has_bytes;
            result.row_end         = 1'b1;
         end else if (state.row_has_fields) begin
            produce        = 1'b1;
            result.row_end = 1'b1;
         end
      end else begin
         case (state.parse_mode)
            MODE_QUOTED: begin
               if (is_quote) begin
                  state_next.parse_mode = MODE_QPEND;
               end else begin
                  produce                    = 1'b1;
                  result.has_byte            = 1'b1;
                  result.out_byte            = item.in_byte;
                  state_next.field_has_bytes = 1'b1;
               end
            end
            MODE_QPEND: begin
               if (is_quote) begin
                  produce                    = 1'b1;
                  result.has_byte            = 1'b1;
                  result.out_byte            = CH_QUOTE;
                  state_next.field_has_bytes = 1'b1;
                  state_next.parse_mode      = MODE_QUOTED;
               end else begin
                  state_next = plain_state;
                  produce    = plain_produce;
                  result     = plain_result;
               end
            end
            MODE_CRPEND: begin
               if (item.in_byte == CH_LF) begin
                  state_next.parse_mode = MODE_PLAIN;
               end else begin
                  state_next = plain_state;
                  produce    = plain_produce;
                  result     = plain_result;
               end
            end
            default: begin
               state_next = plain_state;
               produce    = plain_produce;
               result     = plain_result;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[tb/csv_field_tokenizer_tb.sv]
// Self-checking testbench of the CSV field tokenizer: a scoreboard class predicts
// each token item from the byte stream; a task and initial blocks drive both sides.
// Depends on csvt_pkg, csvt_if.sv and csv_field_tokenizer.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
   import csvt_pkg::*;

   // Lower bound on the number of random input items after the directed opening.
   localparam int RANDOM_ITEMS = 600;
   // Cycles to wait once nothing is expected any more.
   localparam int DRAIN_CYCLES = 8;

   // The scoreboard keeps its own copy of the parse state. Each accepted input
   // item moves that state on and may queue one expected token item; each token
   // item taken from the block is compared with the oldest one waiting.
   class token_scoreboard;
      csvt_mode_type   mode;
      logic            field_nonempty;
      logic            row_started;
      csvt_result_type expected_tokens[$];
      int              mismatch_count;

      function new();
         clear_state();
         mismatch_count = 0;
      endfunction

      function void clear_state();
         mode           = MODE_PLAIN;
         field_nonempty = 1'b0;
         row_started    = 1'b0;
      endfunction

      // A byte seen outside quotes. Returns 1 when it gives a token item.
      function bit unquoted_step(input logic [7:0] c, output csvt_result_type r);
         r = '0;
         if (c == CH_QUOTE) begin
            // A quote opens a quoted section, even part way through a field.
            mode = MODE_QUOTED;
            return 1'b0;
         end
         if (c == CH_COMMA) begin
            r.field_end       = 1'b1;
            r.field_was_empty = !field_nonempty;
            field_nonempty    = 1'b0;
            row_started       = 1'b1;
            mode              = MODE_PLAIN;
            return 1'b1;
         end
         if (c == CH_CR || c == CH_LF) begin
            r.field_end       = 1'b1;
            r.field_was_empty = !field_nonempty;
            r.row_end         = 1'b1;
            field_nonempty    = 1'b0;
            row_started       = 1'b0;
            // After a CR, an LF that follows at once belongs to the same row end.
            mode              = (c == CH_CR) ? MODE_CRPEND : MODE_PLAIN;
            return 1'b1;
         end
         r.has_byte     = 1'b1;
         r.out_byte     = c;
         field_nonempty = 1'b1;
         mode           = MODE_PLAIN;
         return 1'b1;
      endfunction

      function void note_item(input csvt_item_type it);
         csvt_result_type r;
         bit              produced;
         r        = '0;
         produced = 1'b0;
         if (it.func == FUNC_EOI) begin
            // A pending quote counts as closed quotes here; only open quotes
            // force the field to be closed.
            if (mode == MODE_CRPEND) begin
               produced = 1'b0;
            end else if (field_nonempty || mode == MODE_QUOTED) begin
               r.field_end       = 1'b1;
               r.field_was_empty = !field_nonempty;
               r.row_end         = 1'b1;
               produced          = 1'b1;
            end else if (row_started) begin
               r.row_end = 1'b1;
               produced  = 1'b1;
            end
            clear_state();
         end else begin
            case (mode)
               MODE_QUOTED: begin
                  if (it.in_byte == CH_QUOTE) begin
                     mode = MODE_QPEND;
                  end else begin
                     r.has_byte     = 1'b1;
                     r.out_byte     = it.in_byte;
                     field_nonempty = 1'b1;
                     produced       = 1'b1;
                  end
               end
               MODE_QPEND: begin
                  if (it.in_byte == CH_QUOTE) begin
                     // A doubled quote stands for one literal quote.
                     r.has_byte     = 1'b1;
                     r.out_byte     = CH_QUOTE;
                     field_nonempty = 1'b1;
                     mode           = MODE_QUOTED;
                     produced       = 1'b1;
                  end else begin
                     mode     = MODE_PLAIN;
                     produced = unquoted_step(it.in_byte, r);
                  end
               end
               MODE_CRPEND: begin
                  mode = MODE_PLAIN;
                  if (it.in_byte != CH_LF) begin
                     produced = unquoted_step(it.in_byte, r);
                  end
               end
               default: begin
                  produced = unquoted_step(it.in_byte, r);
               end
            endcase
         end
         if (produced) begin
            expected_tokens = {expected_tokens, r};
         end
      endfunction

      function void compare_field(input string name, input int want, input int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(input csvt_result_type got);
         csvt_result_type want;
         if (expected_tokens.size() == 0) begin
            $error("token item with none expected: %p", got);
            mismatch_count++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("has_byte", int'(want.has_byte), int'(got.has_byte));
         compare_field("out_byte", int'(want.out_byte), int'(got.out_byte));
         compare_field("field_end", int'(want.field_end), int'(got.field_end));
         compare_field("field_was_empty", int'(want.field_was_empty),
                       int'(got.field_was_empty));
         compare_field("row_end", int'(want.row_end), int'(got.row_end));
      endfunction
   endclass

   logic clock;
   logic reset;

   csvt_req_if req_ch();
   csvt_rsp_if rsp_ch();

   csv_field_tokenizer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   token_scoreboard board = new();
   csvt_item_type   stim_q[$];
   // When set, neither side idles; the driver changes it every few dozen items
   // so that some stretches run at the full rate.
   bit              no_idle;
   logic [7:0]      specials[4] = '{CH_QUOTE, CH_COMMA, CH_CR, CH_LF};

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // The run must end long before this; the slowest correct run, with every item
   // meeting the longest gap and the longest stall, is well under a millisecond.
   initial begin
      #(5_000_000);
      $display("csv_field_tokenizer_tb NOT OK");
      $finish;
   end

   // Idle lengths: mostly short gaps, now and then a long stretch.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         return 1;
      end else if (pick < 88) begin
         return $urandom_range(2, 4);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic void push_byte(input logic [7:0] c);
      csvt_item_type it;
      it.func    = FUNC_BYTE;
      it.in_byte = c;
      stim_q     = {stim_q, it};
   endfunction

   // The byte field of an end-of-input item is ignored, so it carries noise.
   function automatic void push_eoi();
      csvt_item_type it;
      it.func    = FUNC_EOI;
      it.in_byte = 8'($urandom_range(0, 255));
      stim_q     = {stim_q, it};
   endfunction

   function automatic logic [7:0] ordinary_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
      return c;
   endfunction

   // One field of well-formed text: unquoted, quoted (with separators, line
   // breaks and doubled quotes inside) or empty.
   function automatic void add_field();
      int kind;
      int len;
      int pick;
      kind = $urandom_range(0, 3);
      len  = $urandom_range(0, 5);
      if (kind <= 1) begin
         repeat (len) push_byte(ordinary_char());
      end else if (kind == 2) begin
         push_byte(CH_QUOTE);
         repeat (len) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               push_byte(CH_QUOTE);
               push_byte(CH_QUOTE);
            end else if (pick <= 3) begin
               push_byte(specials[2'(pick)]);
            end else begin
               push_byte(ordinary_char());
            end
         end
         push_byte(CH_QUOTE);
      end
   endfunction

   // A short document: a few rows of a few fields, with LF, CR LF or bare CR
   // row ends, sometimes without a final row end, often closed by end of input.
   function automatic void add_document();
      int rows;
      int fields;
      int ending;
      rows = $urandom_range(1, 4);
      for (int row = 0; row < rows; row++) begin
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) begin
               push_byte(CH_COMMA);
            end
            add_field();
         end
         ending = $urandom_range(0, 3);
         if (ending == 0) begin
            push_byte(CH_LF);
         end else if (ending == 1) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
         end else if (ending == 2) begin
            push_byte(CH_CR);
         end else if (row < rows - 1) begin
            push_byte(CH_LF);
         end
      end
      if ($urandom_range(0, 2) != 0) begin
         push_eoi();
      end
   endfunction

   // Broken text: stray quotes, separators, any byte at all and end marks.
   function automatic void add_noise();
      int count;
      int pick;
      count = $urandom_range(1, 6);
      repeat (count) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            push_eoi();
         end else if (pick <= 3) begin
            push_byte(specials[2'($urandom_range(0, 3))]);
         end else begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Directed opening: every rule of the tokenizer once, then random text.
   function automatic void build_stimulus();
      int directed;
      push_byte("a");          // plain content byte
      push_byte(CH_COMMA);     // field with bytes ends
      push_byte(CH_COMMA);     // empty field ends
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_QUOTE);     // quoted section opens
      push_byte(CH_COMMA);     // comma inside quotes is content
      push_byte(CH_CR);        // so are line breaks
      push_byte(CH_LF);
      push_byte(CH_QUOTE);
      push_byte(CH_QUOTE);     // doubled quote gives one literal quote
      push_byte(CH_QUOTE);
      push_byte("x");          // pending quote, then a plain byte
      push_byte(CH_CR);        // row ends, LF now pending
      push_byte(CH_LF);        // swallowed
      push_byte(CH_QUOTE);
      push_byte(CH_QUOTE);
      push_byte(CH_CR);        // empty quoted field closed by a row end
      push_byte("b");          // pending CR, then a plain byte
      push_byte(CH_QUOTE);     // quote in the middle of an unquoted field
      push_eoi();              // end of input with quotes still open
      push_byte(CH_COMMA);
      push_eoi();              // only the row end is left to give
      push_eoi();              // nothing at all to close
      push_byte(CH_LF);        // bare LF ends an empty row
      push_byte(CH_CR);
      push_eoi();              // CR pending at end of input
      push_byte(CH_QUOTE);
      push_eoi();              // open, empty quoted field at end of input
      directed = stim_q.size();
      while (stim_q.size() < directed + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            add_document();
         end else begin
            add_noise();
         end
      end
   endfunction

   // Presents one input item after an optional gap and holds it until the block
   // takes it. Valid is only ever written once per edge.
   task automatic send_item(input csvt_item_type it);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0) begin
         gap = idle_gap();
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= it.func;
      req_ch.in_byte <= it.in_byte;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_item(it);
   endtask

   // Input side: drives the whole stimulus, then waits for the last token item
   // and a few quiet cycles before giving the verdict.
   initial begin : byte_driver
      int sent;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_BYTE;
      req_ch.in_byte <= 8'h00;
      no_idle = 1'b0;
      build_stimulus();
      @(posedge clock);
      while (reset) @(posedge clock);
      sent = 0;
      while (stim_q.size() > 0) begin
         if (sent % 40 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         send_item(stim_q.pop_front());
         sent++;
      end
      req_ch.valid <= 1'b0;
      while (board.expected_tokens.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.expected_tokens.size() == 0) begin
         $display("csv_field_tokenizer_tb OK");
      end else begin
         $display("csv_field_tokenizer_tb NOT OK");
      end
      $finish;
   end

   // Result side: takes token items at every edge where both valid and ready
   // are high, and stalls now and then for a random stretch.
   initial begin : token_sink
      int              stall_left;
      csvt_result_type got;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.has_byte        = rsp_ch.has_byte;
            got.out_byte        = rsp_ch.out_byte;
            got.field_end       = rsp_ch.field_end;
            got.field_was_empty = rsp_ch.field_was_empty;
            got.row_end         = rsp_ch.row_end;
            board.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) begin
               stall_left = idle_gap();
            end
         end
      end
   end

endmodule

[filelist.f]
hdl/csvt_pkg.sv
hdl/csvt_if.sv
hdl/csvt_step.sv
hdl/csv_field_tokenizer.sv
tb/csv_field_tokenizer_tb.sv
